/* rtl/tlrq_pkg.sv */
// Shared constants, types and command/status structs of the ready queue scheduler.
package tlrq_pkg;

  localparam int NUM_PROCS   = 64;
  localparam int NUM_LEVELS  = 3;
  localparam int PID_W       = 6;
  localparam int LVL_W       = 2;
  localparam int AGE_W       = 8;
  localparam int PTR_W       = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int CNT_W       = $clog2(NUM_PROCS + 1);
  localparam int STORE_DEPTH = NUM_LEVELS * NUM_PROCS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  // Register reset values
  localparam logic             AGING_ENABLE_RST  = 1'b1;
  localparam logic [AGE_W-1:0] AGING_QUANTUM_RST = AGE_W'(10);

  // Register indexes
  localparam logic REG_AGING_ENABLE  = 1'b0;
  localparam logic REG_AGING_QUANTUM = 1'b1;

  typedef logic [LVL_W-1:0] lvl_t;

  // Queue levels
  localparam lvl_t LVL_LOW  = 2'd0;
  localparam lvl_t LVL_MED  = 2'd1;
  localparam lvl_t LVL_HIGH = 2'd2;

  // Item commands
  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_RESCHED = 1'b1;

  typedef struct packed {
    logic load_item;
    logic rd_en;
    lvl_t rd_lvl;
    logic wr_en;
    lvl_t wr_lvl;
    logic wr_from_mem;
    logic med_tick;
    logic low_dec;
    logic low_reload;
    logic set_full;
    logic set_found;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [NUM_LEVELS-1:0] q_nz;
    logic [NUM_LEVELS-1:0] q_full;
    logic                  med_hit;
    logic                  low_zero;
    logic                  is_insert;
    logic                  running;
    lvl_t                  prio;
    logic                  out_busy;
  } dp_stat_t;

endpackage

/* rtl/tlrq_if.sv */
// Valid/ready channel interfaces for scheduler requests and results.
interface tlrq_req_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [tlrq_pkg::PID_W-1:0] proc_id;
  logic [tlrq_pkg::LVL_W-1:0] prio_level;
  logic                       still_running;

  modport source (output valid, cmd, proc_id, prio_level, still_running, input ready);
  modport sink (input valid, cmd, proc_id, prio_level, still_running, output ready);
endinterface

interface tlrq_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [tlrq_pkg::PID_W-1:0] next_proc;
  logic                       next_valid;
  logic                       queue_full;

  modport source (output valid, next_proc, next_valid, queue_full, input ready);
  modport sink (input valid, next_proc, next_valid, queue_full, output ready);
endinterface

/* rtl/tlrq_datapath.sv */
// Queue memory, pointers, aging counters, item and result registers.
module tlrq_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  tlrq_pkg::dp_cmd_t                 c,
  output tlrq_pkg::dp_stat_t                s,
  input  logic [tlrq_pkg::AGE_W-1:0]        aging_quantum,
  input  logic                              in_cmd,
  input  logic [tlrq_pkg::PID_W-1:0]        in_proc_id,
  input  logic [tlrq_pkg::LVL_W-1:0]        in_prio_level,
  input  logic                              in_still_running,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [tlrq_pkg::PID_W-1:0]        out_next_proc,
  output logic                              out_next_valid,
  output logic                              out_queue_full
);
  import tlrq_pkg::*;

  logic [PID_W-1:0] store [STORE_DEPTH];
  logic [PID_W-1:0] rd_data;
  logic [PTR_W-1:0] head [NUM_LEVELS];
  logic [PTR_W-1:0] tail [NUM_LEVELS];
  logic [CNT_W-1:0] cnt  [NUM_LEVELS];
  logic [AGE_W-1:0] med_cnt;
  logic [AGE_W-1:0] low_cnt;

  logic             it_cmd;
  logic [PID_W-1:0] it_pid;
  lvl_t             it_prio;
  logic             it_run;
  logic             full_flag;
  logic             found;

  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [PID_W-1:0]  wr_data;

  function automatic logic [ADDR_W-1:0] q_addr(lvl_t lvl, logic [PTR_W-1:0] ptr);
    q_addr = ADDR_W'(lvl) * ADDR_W'(NUM_PROCS) + ADDR_W'(ptr);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] ptr);
    if (ptr == PTR_W'(NUM_PROCS - 1)) begin
      ptr_inc = '0;
    end else begin
      ptr_inc = ptr + PTR_W'(1);
    end
  endfunction

  assign rd_addr = q_addr(c.rd_lvl, head[c.rd_lvl]);
  assign wr_addr = q_addr(c.wr_lvl, tail[c.wr_lvl]);
  assign wr_data = c.wr_from_mem ? rd_data : it_pid;

  // Queue storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (c.wr_en) begin
      store[wr_addr] <= wr_data;
    end
    if (c.rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

  // Advance head on pop, tail on push
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        cnt[i]  <= '0;
      end
    end else begin
      if (c.rd_en) begin
        head[c.rd_lvl] <= ptr_inc(head[c.rd_lvl]);
        cnt[c.rd_lvl]  <= cnt[c.rd_lvl] - CNT_W'(1);
      end
      if (c.wr_en) begin
        tail[c.wr_lvl] <= ptr_inc(tail[c.wr_lvl]);
        cnt[c.wr_lvl]  <= cnt[c.wr_lvl] + CNT_W'(1);
      end
    end
  end

  // Aging counters: medium reloads when it hits, low saturates at zero
  always_ff @(posedge clk) begin
    if (rst) begin
      med_cnt <= AGING_QUANTUM_RST;
      low_cnt <= AGING_QUANTUM_RST;
    end else begin
      if (c.med_tick) begin
        med_cnt <= s.med_hit ? aging_quantum : med_cnt - AGE_W'(1);
      end
      if (c.low_reload) begin
        low_cnt <= aging_quantum;
      end else if (c.low_dec && low_cnt != '0) begin
        low_cnt <= low_cnt - AGE_W'(1);
      end
    end
  end

  // Hold the accepted word, clamp priority three to high
  always_ff @(posedge clk) begin
    if (c.load_item) begin
      it_cmd  <= in_cmd;
      it_pid  <= in_proc_id;
      it_prio <= (in_prio_level > LVL_HIGH) ? LVL_HIGH : in_prio_level;
      it_run  <= in_still_running;
    end
  end

  // Result flags of the current word
  always_ff @(posedge clk) begin
    if (rst) begin
      full_flag <= 1'b0;
      found     <= 1'b0;
    end else if (c.load_item) begin
      full_flag <= 1'b0;
      found     <= 1'b0;
    end else begin
      if (c.set_full) begin
        full_flag <= 1'b1;
      end
      if (c.set_found) begin
        found <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (c.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c.load_out) begin
      out_next_proc  <= found ? rd_data : '0;
      out_next_valid <= found;
      out_queue_full <= full_flag;
    end
  end

  // Status to the controller
  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      s.q_nz[i]   = (cnt[i] != '0);
      s.q_full[i] = (cnt[i] == CNT_W'(NUM_PROCS));
    end
    s.med_hit   = (med_cnt <= AGE_W'(1));
    s.low_zero  = (low_cnt == '0);
    s.is_insert = (it_cmd == CMD_INSERT);
    s.running   = it_run;
    s.prio      = it_prio;
    s.out_busy  = out_valid && !out_ready;
  end

  a_no_rd_wr_same: assert property (@(posedge clk) disable iff (rst)
    !(c.rd_en && c.wr_en))
    else $error("queue read and write issued together");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    c.wr_en |-> !s.q_full[c.wr_lvl])
    else $error("push into a full queue");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    c.rd_en |-> s.q_nz[c.rd_lvl])
    else $error("pop from an empty queue");

  a_load_out_free: assert property (@(posedge clk) disable iff (rst)
    c.load_out |-> !s.out_busy)
    else $error("result overwritten before it was taken");

endmodule

/* rtl/tlrq_ctrl.sv */
// Sequencer that steps one word through insert, or aging, requeue and dequeue.
module tlrq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_cmd,
  output logic               in_ready,
  input  logic               aging_enable,
  input  tlrq_pkg::dp_stat_t s,
  output tlrq_pkg::dp_cmd_t  c
);
  import tlrq_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_AGE_M  = 3'd1;
  localparam logic [2:0] S_MOVE_M = 3'd2;
  localparam logic [2:0] S_AGE_L  = 3'd3;
  localparam logic [2:0] S_MOVE_L = 3'd4;
  localparam logic [2:0] S_PUSH   = 3'd5;
  localparam logic [2:0] S_POP    = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] after_age;

  assign in_ready  = (state == S_IDLE);
  assign after_age = s.running ? S_PUSH : S_POP;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode state into datapath commands
  always_comb begin
    c          = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          c.load_item = 1'b1;
          state_next  = (in_cmd == CMD_INSERT) ? S_PUSH : S_AGE_M;
        end
      end
      S_AGE_M: begin
        if (!aging_enable) begin
          state_next = after_age;
        end else begin
          c.med_tick = 1'b1;
          if (s.med_hit && s.q_nz[LVL_MED] && !s.q_full[LVL_HIGH]) begin
            c.rd_en    = 1'b1;
            c.rd_lvl   = LVL_MED;
            state_next = S_MOVE_M;
          end else begin
            state_next = S_AGE_L;
          end
        end
      end
      S_MOVE_M: begin
        c.wr_en       = 1'b1;
        c.wr_lvl      = LVL_HIGH;
        c.wr_from_mem = 1'b1;
        c.low_dec     = 1'b1;
        state_next    = S_AGE_L;
      end
      S_AGE_L: begin
        state_next = after_age;
        if (s.low_zero) begin
          c.low_reload = 1'b1;
          if (s.q_nz[LVL_LOW] && !s.q_full[LVL_MED]) begin
            c.rd_en    = 1'b1;
            c.rd_lvl   = LVL_LOW;
            state_next = S_MOVE_L;
          end
        end
      end
      S_MOVE_L: begin
        c.wr_en       = 1'b1;
        c.wr_lvl      = LVL_MED;
        c.wr_from_mem = 1'b1;
        state_next    = after_age;
      end
      S_PUSH: begin
        if (s.q_full[s.prio]) begin
          c.set_full = 1'b1;
        end else begin
          c.wr_en  = 1'b1;
          c.wr_lvl = s.prio;
        end
        state_next = s.is_insert ? S_DONE : S_POP;
      end
      S_POP: begin
        // Take the head of the highest nonempty level
        priority if (s.q_nz[LVL_HIGH]) begin
          c.rd_en     = 1'b1;
          c.rd_lvl    = LVL_HIGH;
          c.set_found = 1'b1;
        end else if (s.q_nz[LVL_MED]) begin
          c.rd_en     = 1'b1;
          c.rd_lvl    = LVL_MED;
          c.set_found = 1'b1;
        end else if (s.q_nz[LVL_LOW]) begin
          c.rd_en     = 1'b1;
          c.rd_lvl    = LVL_LOW;
          c.set_found = 1'b1;
        end else begin
          c.set_found = 1'b0;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!s.out_busy) begin
          c.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
    endcase
  end

endmodule

/* rtl/three_level_ready_queue_aging.sv */
// Top level: configuration registers, sequencer and queue datapath.
//
// Three-level ready queue scheduler with aging, for one core.
// req channel (valid/ready): cmd 0 inserts proc_id at the tail of queue
// prio_level (3 counts as high); cmd 1 reschedules: optional aging
// promotions, requeue of proc_id when still_running, then dequeue of the
// head of the highest nonempty queue. Every word yields one rsp word with
// next_proc, next_valid and queue_full.
// The APB port holds aging_enable (0x0) and aging_quantum (0x4); write
// them only while the block is idle.
// Sequencing: an insert steps through the push and done states; a
// reschedule steps each promotion, the requeue and the dequeue in turn
// through the single read port and single write port of the queue memory.
// The result sits in an output register, so the next word is taken while
// it waits on rsp.ready; if the previous result is still held, the
// sequencer waits before loading.
// Reset empties all queues, sets aging_enable to 1, aging_quantum and
// both aging counters to 10. Queue memory contents are not cleared.
module three_level_ready_queue_aging (
  input  logic                             clk,
  input  logic                             rst,
  tlrq_req_if.sink                         req,
  tlrq_rsp_if.source                       rsp,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tlrq_pkg::PADDR_W-1:0]     paddr,
  input  logic [tlrq_pkg::PDATA_W-1:0]     pwdata,
  output logic [tlrq_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);
  import tlrq_pkg::*;

  logic             aging_enable;
  logic [AGE_W-1:0] aging_quantum;
  logic             reg_sel;
  logic             cfg_wr;
  dp_cmd_t          c;
  dp_stat_t         s;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      aging_enable  <= AGING_ENABLE_RST;
      aging_quantum <= AGING_QUANTUM_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_AGING_ENABLE:  aging_enable  <= pwdata[0];
        REG_AGING_QUANTUM: aging_quantum <= pwdata[AGE_W-1:0];
      endcase
    end
  end

  // Configuration read
  always_comb begin
    unique case (reg_sel)
      REG_AGING_ENABLE:  prdata = PDATA_W'(aging_enable);
      REG_AGING_QUANTUM: prdata = PDATA_W'(aging_quantum);
    endcase
  end

  tlrq_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (req.valid),
    .in_cmd       (req.cmd),
    .in_ready     (req.ready),
    .aging_enable (aging_enable),
    .s            (s),
    .c            (c)
  );

  tlrq_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .c                (c),
    .s                (s),
    .aging_quantum    (aging_quantum),
    .in_cmd           (req.cmd),
    .in_proc_id       (req.proc_id),
    .in_prio_level    (req.prio_level),
    .in_still_running (req.still_running),
    .out_ready        (rsp.ready),
    .out_valid        (rsp.valid),
    .out_next_proc    (rsp.next_proc),
    .out_next_valid   (rsp.next_valid),
    .out_queue_full   (rsp.queue_full)
  );

endmodule
